[rtl/assert_macros.svh]
// Assertion helper macros shared by the decoder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Same-cycle implication outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[rtl/u8u16_pkg.sv]
// Package for the UTF-8 to UTF-16 decoder: result types, byte class masks,
// capacity and queue sizing, and the unit emit helper. No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam int unsigned MaxCapacity = 4096;
  localparam int unsigned CapW        = 13;
  localparam int unsigned UnitW       = $clog2(MaxCapacity);
  localparam int unsigned MaxPush     = 3;
  localparam int unsigned FifoDepth   = 8;
  localparam int unsigned FifoAw      = $clog2(FifoDepth);

  // byte classes
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Tag  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Tag  = 8'hE0;

  // held byte count and expected sequence length codes
  localparam logic [1:0] HeldNone  = 2'd0;
  localparam logic [1:0] HeldOne   = 2'd1;
  localparam logic [1:0] HeldTwo   = 2'd2;
  localparam logic [1:0] SeqNone   = 2'd0;
  localparam logic [1:0] SeqTwo    = 2'd2;
  localparam logic [1:0] SeqThree  = 2'd3;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_term;
    logic        malformed;
    logic        truncated;
  } res_t;

  // results produced by one input byte, in order
  typedef struct packed {
    logic [1:0]         n;
    res_t [MaxPush-1:0] res;
  } push_t;

  typedef struct packed {
    push_t            push;
    logic [UnitW-1:0] uw;
    logic             stop;
  } emit_acc_t;

  // Append one data unit, or a truncated terminator if the limit is reached.
  function automatic emit_acc_t emit_unit(emit_acc_t a, logic [15:0] unit, logic bad,
                                          logic [UnitW-1:0] limit);
    emit_acc_t r;
    r = a;
    if (!a.stop) begin
      if (a.uw >= limit) begin
        r.push.res[a.push.n] = '{code_unit: 16'h0, is_term: 1'b1, malformed: 1'b0,
                                 truncated: 1'b1};
        r.push.n = a.push.n + 2'd1;
        r.stop   = 1'b1;
      end else begin
        r.push.res[a.push.n] = '{code_unit: unit, is_term: 1'b0, malformed: bad,
                                 truncated: 1'b0};
        r.push.n = a.push.n + 2'd1;
        r.uw     = a.uw + UnitW'(1);
      end
    end
    return r;
  endfunction

endpackage

[rtl/u8u16_decode.sv]
// Byte decoder: sequence state registers and the per-byte result logic.
// Depends on u8u16_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8u16_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [7:0]                  byte_i,
  input  logic [u8u16_pkg::CapW-1:0]  cap_i,
  output u8u16_pkg::push_t            push_o
);

  logic [7:0]                  lead_q, lead_d;
  logic [7:0]                  second_q, second_d;
  logic [1:0]                  held_q, held_d;
  logic [1:0]                  seq_q, seq_d;
  logic [u8u16_pkg::UnitW-1:0] uw_q, uw_d;
  logic                        drop_q, drop_d;
  logic [u8u16_pkg::UnitW-1:0] limit;
  u8u16_pkg::emit_acc_t        acc;
  logic                        do_fresh;

  // clamp capacity into [2, MaxCapacity], one slot kept for the terminator
  always_comb begin
    if (cap_i < u8u16_pkg::CapW'(2)) begin
      limit = u8u16_pkg::UnitW'(1);
    end else if (cap_i > u8u16_pkg::CapW'(u8u16_pkg::MaxCapacity)) begin
      limit = u8u16_pkg::UnitW'(u8u16_pkg::MaxCapacity - 1);
    end else begin
      limit = u8u16_pkg::UnitW'(cap_i - u8u16_pkg::CapW'(1));
    end
  end

  always_comb begin
    acc      = '0;
    acc.uw   = uw_q;
    lead_d   = lead_q;
    second_d = second_q;
    held_d   = held_q;
    seq_d    = seq_q;
    drop_d   = drop_q;
    do_fresh = 1'b0;
    if (valid_i) begin
      if (drop_q) begin
        if (byte_i == 8'h00) begin
          drop_d = 1'b0;
          acc.uw = '0;
        end
      end else begin
        if (held_q != u8u16_pkg::HeldNone) begin
          if ((byte_i & u8u16_pkg::ContMask) == u8u16_pkg::ContTag) begin
            if (seq_q == u8u16_pkg::SeqThree && held_q == u8u16_pkg::HeldOne) begin
              second_d = byte_i;
              held_d   = u8u16_pkg::HeldTwo;
            end else begin
              if (seq_q == u8u16_pkg::SeqThree) begin
                acc = u8u16_pkg::emit_unit(acc, {lead_q[3:0], second_q[5:0], byte_i[5:0]},
                                           1'b0, limit);
              end else begin
                acc = u8u16_pkg::emit_unit(acc, {5'b0, lead_q[4:0], byte_i[5:0]},
                                           1'b0, limit);
              end
              lead_d   = '0;
              second_d = '0;
              held_d   = u8u16_pkg::HeldNone;
              seq_d    = u8u16_pkg::SeqNone;
            end
          end else begin
            // broken sequence: held bytes go out raw, then the byte starts over
            acc = u8u16_pkg::emit_unit(acc, {8'h00, lead_q}, 1'b1, limit);
            if (held_q >= u8u16_pkg::HeldTwo) begin
              acc = u8u16_pkg::emit_unit(acc, {8'h00, second_q}, 1'b1, limit);
            end
            lead_d   = '0;
            second_d = '0;
            held_d   = u8u16_pkg::HeldNone;
            seq_d    = u8u16_pkg::SeqNone;
            do_fresh = 1'b1;
          end
        end else begin
          do_fresh = 1'b1;
        end

        if (do_fresh && !acc.stop) begin
          if (byte_i == 8'h00) begin
            acc.push.res[acc.push.n] = '{code_unit: 16'h0, is_term: 1'b1, malformed: 1'b0,
                                         truncated: 1'b0};
            acc.push.n = acc.push.n + 2'd1;
            acc.uw     = '0;
          end else if (!byte_i[7]) begin
            acc = u8u16_pkg::emit_unit(acc, {9'h000, byte_i[6:0]}, 1'b0, limit);
          end else if ((byte_i & u8u16_pkg::Lead2Mask) == u8u16_pkg::Lead2Tag) begin
            lead_d = byte_i;
            held_d = u8u16_pkg::HeldOne;
            seq_d  = u8u16_pkg::SeqTwo;
          end else if ((byte_i & u8u16_pkg::Lead3Mask) == u8u16_pkg::Lead3Tag) begin
            lead_d = byte_i;
            held_d = u8u16_pkg::HeldOne;
            seq_d  = u8u16_pkg::SeqThree;
          end else begin
            acc = u8u16_pkg::emit_unit(acc, {8'h00, byte_i}, 1'b1, limit);
          end
        end

        // forced terminator: skip the rest of the string
        if (acc.stop) begin
          lead_d   = '0;
          second_d = '0;
          held_d   = u8u16_pkg::HeldNone;
          seq_d    = u8u16_pkg::SeqNone;
          acc.uw   = '0;
          drop_d   = (byte_i != 8'h00);
        end
      end
    end
    uw_d = acc.uw;
  end

  assign push_o = acc.push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q   <= '0;
      second_q <= '0;
      held_q   <= u8u16_pkg::HeldNone;
      seq_q    <= u8u16_pkg::SeqNone;
      uw_q     <= '0;
      drop_q   <= 1'b0;
    end else begin
      lead_q   <= lead_d;
      second_q <= second_d;
      held_q   <= held_d;
      seq_q    <= seq_d;
      uw_q     <= uw_d;
      drop_q   <= drop_d;
    end
  end

  `ASSERT_IMPL(drop_is_quiet, clk_i, rst_ni, valid_i && drop_q, push_o.n == 2'd0)
  `ASSERT_IMPL(held_is_lead, clk_i, rst_ni, held_q != u8u16_pkg::HeldNone,
               lead_q[7:6] == 2'b11 && drop_q == 1'b0)
  `ASSERT_ALWAYS(units_in_limit, clk_i, rst_ni,
                 uw_q <= u8u16_pkg::UnitW'(u8u16_pkg::MaxCapacity - 1))

endmodule

[rtl/u8u16_fifo.sv]
// Result queue: takes up to three results per cycle, hands out one per cycle while ready_i is high.
// Depends on u8u16_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8u16_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  u8u16_pkg::push_t        push_i,
  input  logic                    reserve_i,
  output logic                    room_o,
  output logic                    valid_o,
  input  logic                    ready_i,
  output u8u16_pkg::res_t         head_o
);

  u8u16_pkg::res_t                 mem_q [u8u16_pkg::FifoDepth];
  logic [u8u16_pkg::FifoAw-1:0]    wr_q, wr_d;
  logic [u8u16_pkg::FifoAw-1:0]    rd_q, rd_d;
  logic [u8u16_pkg::FifoAw:0]      cnt_q, cnt_d;
  logic                            pop;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;

  // space for a full burst from the byte in the decoder and one more behind it
  assign room_o = (cnt_q + (reserve_i ? (u8u16_pkg::FifoAw + 1)'(u8u16_pkg::MaxPush)
                                      : '0))
                  <= (u8u16_pkg::FifoAw + 1)'(u8u16_pkg::FifoDepth - u8u16_pkg::MaxPush);

  assign wr_d  = wr_q + u8u16_pkg::FifoAw'(push_i.n);
  assign rd_d  = rd_q + u8u16_pkg::FifoAw'(pop);
  assign cnt_d = cnt_q + (u8u16_pkg::FifoAw + 1)'(push_i.n)
               - (u8u16_pkg::FifoAw + 1)'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < u8u16_pkg::MaxPush; i++) begin
      if (2'(i) < push_i.n) begin
        mem_q[wr_q + u8u16_pkg::FifoAw'(i)] <= push_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_ALWAYS(no_overflow, clk_i, rst_ni,
                 cnt_q + (u8u16_pkg::FifoAw + 1)'(push_i.n)
                 <= (u8u16_pkg::FifoAw + 1)'(u8u16_pkg::FifoDepth))

endmodule

[rtl/utf8_to_utf16_decoder.sv]
// Top level of the UTF-8 to UTF-16 decoder: capacity register, input stage,
// byte decoder and result queue. Depends on u8u16_pkg, u8u16_decode, u8u16_fifo.
//
// Usage:
//   Bytes enter on s_axis (tdata = byte). Code units leave on m_axis:
//   tdata = UTF-16 unit, tlast = terminator, tuser[0] = malformed raw byte,
//   tuser[1] = terminator forced by capacity. A zero byte ends a string.
//   cfg_we_i/cfg_wdata_i write the output capacity (units, terminator
//   included); write it only while no request is in flight.
// Timing:
//   A byte is registered, decoded in the next cycle and its results land in
//   an 8-entry queue, from which the first result shows on m_axis. One byte
//   per cycle is sustained while each byte gives at most one unit and
//   m_axis_tready stays high; a broken sequence gives up to three units,
//   which drain one per cycle while m_axis_tready is high, and
//   s_axis_tready drops while the queue lacks room for a three-unit burst from
//   the byte in the decoder plus another from a new byte.
// Reset and stall:
//   Reset empties the queue, clears any held sequence and sets capacity to
//   4096. When m_axis_tready is low the queue fills and s_axis_tready falls;
//   no result is lost.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,    // out_capacity
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic        m_axis_tlast,   // is_terminator
  output logic [1:0]  m_axis_tuser    // [0] malformed, [1] truncated
);

  logic [u8u16_pkg::CapW-1:0] cap_q;
  logic                       stg_valid_q;
  logic [7:0]                 stg_byte_q;
  u8u16_pkg::push_t           push;
  u8u16_pkg::res_t            head;
  logic                       room;

  assign s_axis_tready = room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= u8u16_pkg::CapW'(u8u16_pkg::MaxCapacity);
      stg_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      stg_valid_q <= s_axis_tvalid && room;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && room) begin
      stg_byte_q <= s_axis_tdata;
    end
  end

  u8u16_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid_q),
    .byte_i  (stg_byte_q),
    .cap_i   (cap_q),
    .push_o  (push)
  );

  u8u16_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .reserve_i (stg_valid_q),
    .room_o    (room),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .head_o    (head)
  );

  assign m_axis_tdata = head.code_unit;
  assign m_axis_tlast = head.is_term;
  assign m_axis_tuser = {head.truncated, head.malformed};

endmodule
